// ----- rtl/bvg_pkg.sv -----
// Shared package for the battery voltage gauge.
// Widths, the cell curve table, controller state and the command/status types.
// No dependencies.
package bvg_pkg;

    localparam int SAMPLES_DEF = 16;

    localparam int CODE_W   = 12;
    localparam int GAIN_W   = 16;
    localparam int MV_W     = 14;
    localparam int PCT_W    = 15;
    localparam int QBITS    = 14;   // quotient bits of the interpolation divider
    localparam int NUM_W    = 19;   // widest interpolation numerator
    localparam int OFF_W    = 9;    // offset and span inside one curve segment
    localparam int SEG_W    = 5;
    localparam int CURVE_PTS = 21;
    localparam int GAIN_SHIFT = 14; // *2 / 32768

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;
    localparam logic [MV_W-1:0]   MV_MAX     = 14'd16383;
    localparam logic [MV_W-1:0]   FULL_MV    = 14'd4200;
    localparam logic [MV_W-1:0]   EMPTY_MV   = 14'd3270;
    localparam logic [PCT_W-1:0]  PCT_FULL   = 15'd25600;
    localparam int                STEP_Q8    = 1280;

    // APB map: one 32-bit register per word
    localparam int APB_AW = 3;
    typedef logic [APB_AW-3:0] t_reg_idx;
    localparam t_reg_idx REG_CAL_GAIN = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_SEG,
        ST_DIV_PCT,
        ST_DONE,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic acc;        // take the sample on the input
        logic mul;        // product = gain * sum, clear the sum
        logic sat_ld;     // voltage saturates
        logic div_start;
        logic mv_ld;      // voltage from the reciprocal average
        logic seg;        // segment lookup: fixed pct or base capture
        logic pct_ld;     // pct from base + divider
        logic out_ld;
        logic out_err;
    } t_dp_cmd;

    typedef struct packed {
        logic in_last;
        logic in_failed;
        logic sat;
        logic interp;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    // cell curve in mV, 5 percent apart, highest first
    function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            5'd0:  v = 14'd4200;
            5'd1:  v = 14'd4150;
            5'd2:  v = 14'd4110;
            5'd3:  v = 14'd4080;
            5'd4:  v = 14'd4020;
            5'd5:  v = 14'd3980;
            5'd6:  v = 14'd3950;
            5'd7:  v = 14'd3910;
            5'd8:  v = 14'd3870;
            5'd9:  v = 14'd3850;
            5'd10: v = 14'd3840;
            5'd11: v = 14'd3820;
            5'd12: v = 14'd3800;
            5'd13: v = 14'd3790;
            5'd14: v = 14'd3770;
            5'd15: v = 14'd3750;
            5'd16: v = 14'd3730;
            5'd17: v = 14'd3710;
            5'd18: v = 14'd3690;
            5'd19: v = 14'd3610;
            5'd20: v = 14'd3270;
            default: v = '0;
        endcase
        return v;
    endfunction

    // pct*256 at the lower end of segment idx
    function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] idx);
        logic [PCT_W-1:0] step;
        step = PCT_W'(STEP_Q8) * PCT_W'(idx);
        return PCT_FULL - step;
    endfunction

endpackage

// ----- rtl/bvg_div.sv -----
// Restoring divider, one quotient bit per cycle, QBITS quotient bits per division.
// Caller guarantees the quotient fits in QBITS bits. Depends on bvg_pkg.
module bvg_div
    import bvg_pkg::*;
#(
    parameter int DIV_W = NUM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [QBITS-1:0] o_quotient
);

    localparam int EXT_W = DIV_W + QBITS - 1;
    localparam int CNT_W = $clog2(QBITS);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [EXT_W-1:0] r_dsh, n_dsh;
    logic [QBITS-1:0] r_quo, n_quo;

    logic [EXT_W-1:0] rem_ext;
    logic [EXT_W-1:0] diff;
    logic             ge;

    assign rem_ext = EXT_W'(r_rem);
    assign ge      = rem_ext >= r_dsh;
    assign diff    = rem_ext - r_dsh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(QBITS - 1);
            n_rem  = i_dividend;
            n_dsh  = EXT_W'(i_divisor) << (QBITS - 1);
            n_quo  = '0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = diff[DIV_W-1:0];
            end
            n_quo = {r_quo[QBITS-2:0], ge};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/bvg_dp.sv -----
// Datapath: sample accumulator, gain multiply, saturation, curve lookup,
// interpolation divider and output register. Depends on bvg_pkg and bvg_div.
module bvg_dp
    import bvg_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [GAIN_W-1:0] i_cal_gain,
    input  logic [CODE_W-1:0] i_raw_code,
    input  logic [CODE_W-1:0] i_calibrated_mv,
    input  logic              i_calibration_ok,
    input  logic              i_read_failed,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [MV_W-1:0]   o_battery_mv,
    output logic [PCT_W-1:0]  o_charge_pct_q8,
    output logic              o_status
);

    localparam int SUM_W  = $clog2(SAMPLES * 4095 + 1);
    localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int Q_W    = PROD_W - GAIN_SHIFT;
    localparam logic [31:0] SAT_LIM = 32'(16384 * SAMPLES);
    // floor(x / SAMPLES) = (x * RECIP) >> RSH, exact for any Q_W-bit x
    localparam int LOG_S  = $clog2(SAMPLES);
    localparam int RSH    = Q_W + LOG_S;
    localparam int RCP_W  = Q_W + 1;
    localparam int AP_W   = Q_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RSH) + 64'(SAMPLES - 1)) / 64'(SAMPLES));

    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_prod;
    logic [MV_W-1:0]   r_mv;
    logic [PCT_W-1:0]  r_pct;
    logic [PCT_W-1:0]  r_base;
    logic              r_out_valid;
    logic [MV_W-1:0]   r_out_mv;
    logic [PCT_W-1:0]  r_out_pct;
    logic              r_out_st;

    logic [CODE_W-1:0] sample;
    logic [Q_W-1:0]    avg_num;
    logic [AP_W-1:0]   avg_prod;
    logic [MV_W-1:0]   avg_mv;
    logic [SEG_W-1:0]  seg_idx;
    logic [MV_W-1:0]   seg_lo;
    logic [MV_W-1:0]   seg_hi;
    logic [OFF_W-1:0]  offset;
    logic [OFF_W-1:0]  span;
    logic [NUM_W-1:0]  frac_num;
    logic              interp;
    logic              div_done;
    logic [QBITS-1:0]  div_q;

    assign sample   = i_calibration_ok ? i_calibrated_mv : i_raw_code;
    assign avg_num  = r_prod[PROD_W-1:GAIN_SHIFT];
    assign avg_prod = AP_W'(avg_num) * AP_W'(RECIP);
    assign avg_mv   = avg_prod[RSH +: MV_W];

    // first curve point at or below the voltage
    always_comb begin
        seg_idx = '0;
        for (int k = CURVE_PTS - 1; k >= 1; k--) begin
            if (r_mv >= curve_mv(SEG_W'(k))) begin
                seg_idx = SEG_W'(k);
            end
        end
    end

    assign interp   = (r_mv > EMPTY_MV) && (r_mv < FULL_MV);
    assign seg_lo   = curve_mv(seg_idx);
    assign seg_hi   = curve_mv(seg_idx - 1'b1);
    assign offset   = OFF_W'(r_mv - seg_lo);
    assign span     = OFF_W'(seg_hi - seg_lo);
    // offset * 1280
    assign frac_num = (NUM_W'(offset) << 10) + (NUM_W'(offset) << 8);

    bvg_div #(
        .DIV_W (NUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (frac_num),
        .i_divisor  (NUM_W'(span)),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc) begin
            if (i_read_failed) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= r_sum + SUM_W'(sample);
                r_cnt <= o_sts.in_last ? '0 : r_cnt + 1'b1;
            end
        end else if (i_cmd.mul) begin
            r_sum <= '0;
        end
    end

    // scaling and interpolation registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(i_cal_gain) * PROD_W'(r_sum);
        end
        if (i_cmd.sat_ld) begin
            r_mv <= MV_MAX;
        end else if (i_cmd.mv_ld) begin
            r_mv <= avg_mv;
        end
        if (i_cmd.seg) begin
            r_base <= seg_base(seg_idx);
            r_pct  <= (r_mv >= FULL_MV) ? PCT_FULL : '0;
        end else if (i_cmd.pct_ld) begin
            r_pct <= r_base + PCT_W'(div_q);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_ld) begin
            r_out_mv  <= i_cmd.out_err ? '0 : r_mv;
            r_out_pct <= i_cmd.out_err ? '0 : r_pct;
            r_out_st  <= i_cmd.out_err;
        end
    end

    assign o_sts.in_last   = (r_cnt == CNT_W'(SAMPLES - 1));
    assign o_sts.in_failed = i_read_failed;
    assign o_sts.sat       = 32'(avg_num) >= SAT_LIM;
    assign o_sts.interp    = interp;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_battery_mv    = r_out_mv;
    assign o_charge_pct_q8 = r_out_pct;
    assign o_status        = r_out_st;

endmodule

// ----- rtl/bvg_ctrl.sv -----
// Controller state machine: sequences accumulation, scaling, the
// interpolation division and the result hand-off. Depends on bvg_pkg.
module bvg_ctrl
    import bvg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_sts.in_failed) begin
                        n_state = ST_ERR;
                    end else if (i_sts.in_last) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL:     n_state = ST_SAT;
            ST_SAT:     n_state = ST_SEG;
            ST_SEG:     n_state = i_sts.interp ? ST_DIV_PCT : ST_DONE;
            ST_DIV_PCT: if (i_sts.div_done) n_state = ST_DONE;
            ST_DONE:    if (i_sts.out_free) n_state = ST_IDLE;
            ST_ERR:     if (i_sts.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: o_cmd.acc = accept;
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_SAT: begin
                o_cmd.sat_ld = i_sts.sat;
                o_cmd.mv_ld  = !i_sts.sat;
            end
            ST_SEG: begin
                o_cmd.seg       = 1'b1;
                o_cmd.div_start = i_sts.interp;
            end
            ST_DIV_PCT: o_cmd.pct_ld = i_sts.div_done;
            ST_DONE:    o_cmd.out_ld = i_sts.out_free;
            ST_ERR: begin
                o_cmd.out_ld  = i_sts.out_free;
                o_cmd.out_err = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/battery_voltage_gauge.sv -----
// Battery voltage gauge: averages SAMPLES ADC readings, scales by cal_gain, interpolates charge.
// Result path after the batch-ending transfer: multiply, saturate or average, segment lookup,
// then division unless saturated or off the curve ends; a read failure yields an error result.
// Throughput: one sample per cycle inside a batch; a batch end or a read failure blocks the input
// until its result is loaded, longer while the previous result still waits for transfer.
// Reset (synchronous, active low) clears the sum, count and state, cal_gain = 1.0.
module battery_voltage_gauge
    import bvg_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,  // raw_code[11:0], calibrated_mv[23:12]
    input  logic [1:0]        s_axis_tuser,  // calibration_ok[0], read_failed[1]
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // battery_mv[13:0], charge_pct_q8[28:14], 0
    output logic              m_axis_tuser,  // status
    // APB config
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [GAIN_W-1:0] r_cal_gain;
    t_reg_idx          reg_idx;
    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [MV_W-1:0]   out_mv;
    logic [PCT_W-1:0]  out_pct;

    // register file: cal_gain only
    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_CAL_GAIN)) begin
            r_cal_gain <= pwdata[GAIN_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_CAL_GAIN) ? 32'(r_cal_gain) : '0;

    bvg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath; result leaves through its own output register, so the
    // sample side stays open while a result waits for transfer
    bvg_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cal_gain       (r_cal_gain),
        .i_raw_code       (s_axis_tdata[11:0]),
        .i_calibrated_mv  (s_axis_tdata[23:12]),
        .i_calibration_ok (s_axis_tuser[0]),
        .i_read_failed    (s_axis_tuser[1]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_battery_mv     (out_mv),
        .o_charge_pct_q8  (out_pct),
        .o_status         (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, out_pct, out_mv};

endmodule
